/* design/mrd_pkg.sv */
`timescale 1ns / 1ps

package mrd_pkg;

  // Default store depth of one row
  localparam int MAX_SLOTS_DEF = 256;

  // Slot and beat shapes
  localparam int SLOT_W      = 8;
  localparam int FIELD_LANES = 4;
  localparam int LANE_IDX_W  = $clog2(FIELD_LANES);
  localparam int LANES_W     = 3;

  // Cap on beats per row
  localparam int MAX_BEATS = 64;
  localparam int BEAT_CW   = $clog2(MAX_BEATS);

  typedef logic [SLOT_W-1:0] slot_t;

endpackage

/* design/mrd_ram.sv */
`timescale 1ns / 1ps

module mrd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/mrd_gcd.sv */
`timescale 1ns / 1ps

// Subtractive gcd, one subtract per cycle. Both operands must be nonzero.
module mrd_gcd #(
  parameter int W = 9
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] a_in,
  input  logic [W-1:0] b_in,
  output logic         done,
  output logic [W-1:0] result
);

  logic         busy_r, busy_nxt;
  logic [W-1:0] a_r, a_nxt;
  logic [W-1:0] b_r, b_nxt;

  always_comb begin
    busy_nxt = busy_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    if (start) begin
      busy_nxt = 1'b1;
      a_nxt    = a_in;
      b_nxt    = b_in;
    end else if (busy_r) begin
      if (a_r > b_r) begin
        a_nxt = a_r - b_r;
      end else if (b_r > a_r) begin
        b_nxt = b_r - a_r;
      end else begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    b_r <= b_nxt;
  end

  assign done   = busy_r && (a_r == b_r);
  assign result = a_r;

endmodule

/* design/measure_row_decimator.sv */
`timescale 1ns / 1ps

// Measure row decimator.
// Input channel (in_valid/in_ready): one slot per beat, in_last_slot closes the row.
// While a row loads, in_ready is high and a slot is taken every cycle in_valid is
// high; slots past MAX_SLOTS are dropped and reported through out_overflowed.
// After the last slot the stored row is scanned once, each slot read through the
// registered RAM port, with a subtractive gcd run each time a nonzero slot sits off
// the current stride; the scan stops early once the stride reaches one. The row is
// then decimated by that stride in one go, with no rewrite of the store.
// Result channel (out_valid/out_ready): up to four slots per beat, out_is_final on
// the last beat. Each slot of a beat is read from the store into the output register;
// an all-zero row gives a single empty beat. At most 64 beats per row.
// The output register holds its beat while out_ready is low and the block waits;
// no new slot is taken until the final beat of the row is accepted.
// Reset (rst_n, synchronous, active low) clears the row length and overflow flag;
// the slot store needs no clearing pass, since only slots written in the current
// row are read.
module measure_row_decimator
  import mrd_pkg::*;
#(
  parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [SLOT_W-1:0]  in_slot_value,
  input  logic               in_last_slot,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [SLOT_W-1:0]  out_lane0_value,
  output logic [SLOT_W-1:0]  out_lane1_value,
  output logic [SLOT_W-1:0]  out_lane2_value,
  output logic [SLOT_W-1:0]  out_lane3_value,
  output logic [LANES_W-1:0] out_lanes_valid,
  output logic               out_is_final,
  output logic               out_empty_row,
  output logic               out_overflowed
);

  localparam int AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int LW = $clog2(MAX_SLOTS + 1);
  localparam int PW = LW + 1;

  localparam logic [2:0] S_LOAD = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_GCD  = 3'd3;
  localparam logic [2:0] S_ERD  = 3'd4;
  localparam logic [2:0] S_ECAP = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  // control state
  logic [2:0]            state_r, state_nxt;
  logic [LW-1:0]         len_r, len_nxt;
  logic                  ovf_r, ovf_nxt;
  logic [LW-1:0]         i_r, i_nxt;
  logic [LW-1:0]         m_r, m_nxt;
  logic [LW-1:0]         g_r, g_nxt;
  logic [PW-1:0]         p_r, p_nxt;
  logic [LANE_IDX_W-1:0] j_r, j_nxt;
  logic [BEAT_CW-1:0]    beat_r, beat_nxt;

  // output beat register
  slot_t                 lane_r [FIELD_LANES];
  slot_t                 lane_nxt [FIELD_LANES];
  logic [LANES_W-1:0]    nlanes_r, nlanes_nxt;
  logic                  final_r, final_nxt;
  logic                  empty_r, empty_nxt;

  // RAM and gcd hookup
  logic                  ram_we;
  logic [AW-1:0]         ram_raddr;
  slot_t                 ram_rdata;
  logic                  gcd_start;
  logic                  gcd_done;
  logic [LW-1:0]         gcd_res;

  // scan advance terms
  logic [LW-1:0]         adv_g;
  logic [LW-1:0]         adv_m_base;
  logic [LW-1:0]         i_inc;
  logic [LW-1:0]         m_inc;
  logic [LW-1:0]         adv_m;
  logic                  adv_end;
  logic                  in_beat;
  logic                  out_beat;
  logic                  store_ok;
  logic [LW-1:0]         len_fin;
  logic [PW-1:0]         p_step;
  logic                  row_end;

  assign in_ready  = (state_r == S_LOAD);
  assign out_valid = (state_r == S_OUT);
  assign in_beat   = in_valid && in_ready;
  assign out_beat  = out_valid && out_ready;

  assign store_ok = (len_r != LW'(MAX_SLOTS));
  assign len_fin  = store_ok ? (len_r + LW'(1)) : len_r;
  assign ram_we   = in_beat && store_ok;

  // read address: scan index while scanning, stride pointer while emitting
  assign ram_raddr = (state_r == S_ERD) ? p_r[AW-1:0] : i_r[AW-1:0];

  mrd_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (MAX_SLOTS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (len_r[AW-1:0]),
    .wdata (in_slot_value),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // a nonzero slot off the current stride shrinks the stride to gcd(stride, offset)
  assign gcd_start = (state_r == S_CHK) && (ram_rdata != '0) && (m_r != '0);

  mrd_gcd #(
    .W (LW)
  ) u_gcd (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (gcd_start),
    .a_in   (g_r),
    .b_in   (m_r),
    .done   (gcd_done),
    .result (gcd_res)
  );

  // next scan index; after a gcd run the index sits on the new stride
  assign adv_g      = (state_r == S_GCD) ? gcd_res : g_r;
  assign adv_m_base = (state_r == S_GCD) ? '0 : m_r;
  assign i_inc      = i_r + LW'(1);
  assign m_inc      = adv_m_base + LW'(1);
  assign adv_m      = (m_inc == adv_g) ? '0 : m_inc;
  assign adv_end    = (i_inc == len_r) || (adv_g == LW'(1));

  // emit stride
  assign p_step  = p_r + PW'(g_r);
  assign row_end = (p_step >= PW'(len_r));

  always_comb begin
    state_nxt  = state_r;
    len_nxt    = len_r;
    ovf_nxt    = ovf_r;
    i_nxt      = i_r;
    m_nxt      = m_r;
    g_nxt      = g_r;
    p_nxt      = p_r;
    j_nxt      = j_r;
    beat_nxt   = beat_r;
    lane_nxt   = lane_r;
    nlanes_nxt = nlanes_r;
    final_nxt  = final_r;
    empty_nxt  = empty_r;

    case (state_r)
      S_LOAD: begin
        if (in_beat) begin
          len_nxt = len_fin;
          if (!store_ok) begin
            ovf_nxt = 1'b1;
          end
          if (in_last_slot) begin
            g_nxt = len_fin;
            i_nxt = LW'(1);
            if (len_fin == LW'(1)) begin
              m_nxt     = '0;
              p_nxt     = '0;
              j_nxt     = '0;
              beat_nxt  = '0;
              lane_nxt  = '{default: '0};
              state_nxt = S_ERD;
            end else begin
              m_nxt     = LW'(1);
              state_nxt = S_RD;
            end
          end
        end
      end

      S_RD: begin
        state_nxt = S_CHK;
      end

      S_CHK, S_GCD: begin
        if (gcd_start) begin
          state_nxt = S_GCD;
        end else if ((state_r == S_CHK) || gcd_done) begin
          g_nxt = adv_g;
          i_nxt = i_inc;
          m_nxt = adv_m;
          if (adv_end) begin
            p_nxt     = '0;
            j_nxt     = '0;
            beat_nxt  = '0;
            lane_nxt  = '{default: '0};
            state_nxt = S_ERD;
          end else begin
            state_nxt = S_RD;
          end
        end
      end

      S_ERD: begin
        state_nxt = S_ECAP;
      end

      S_ECAP: begin
        p_nxt = p_step;
        if ((g_r == len_r) && (ram_rdata == '0)) begin
          // row reduced to a single zero slot
          nlanes_nxt = '0;
          final_nxt  = 1'b1;
          empty_nxt  = 1'b1;
          state_nxt  = S_OUT;
        end else begin
          lane_nxt[j_r] = ram_rdata;
          if (row_end || (j_r == LANE_IDX_W'(FIELD_LANES - 1))) begin
            nlanes_nxt = LANES_W'(j_r) + LANES_W'(1);
            final_nxt  = row_end || (beat_r == BEAT_CW'(MAX_BEATS - 1));
            empty_nxt  = 1'b0;
            state_nxt  = S_OUT;
          end else begin
            j_nxt     = j_r + LANE_IDX_W'(1);
            state_nxt = S_ERD;
          end
        end
      end

      S_OUT: begin
        if (out_beat) begin
          if (final_r) begin
            len_nxt   = '0;
            ovf_nxt   = 1'b0;
            state_nxt = S_LOAD;
          end else begin
            j_nxt     = '0;
            beat_nxt  = beat_r + BEAT_CW'(1);
            lane_nxt  = '{default: '0};
            state_nxt = S_ERD;
          end
        end
      end

      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      len_r   <= '0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      len_r   <= len_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  // scan and beat datapath
  always_ff @(posedge clk) begin
    i_r      <= i_nxt;
    m_r      <= m_nxt;
    g_r      <= g_nxt;
    p_r      <= p_nxt;
    j_r      <= j_nxt;
    beat_r   <= beat_nxt;
    lane_r   <= lane_nxt;
    nlanes_r <= nlanes_nxt;
    final_r  <= final_nxt;
    empty_r  <= empty_nxt;
  end

  assign out_lane0_value = lane_r[0];
  assign out_lane1_value = lane_r[1];
  assign out_lane2_value = lane_r[2];
  assign out_lane3_value = lane_r[3];
  assign out_lanes_valid = nlanes_r;
  assign out_is_final    = final_r;
  assign out_empty_row   = empty_r;
  assign out_overflowed  = ovf_r;

endmodule
